// ===== design/phr_pkg.sv =====
// ----------------------------------------------------------------------------
// phr_pkg: shared types, constants and helpers of the phase rescaler
// formats, controller commands, status and the ramp wrap helper
// ----------------------------------------------------------------------------
package phr_pkg;

    // phase fraction bits, phases are 24 bits wide
    localparam int PHASE_FRAC_BITS = 23;
    localparam int PHASE_W         = 24;

    // coefficient q2.22, scale and reciprocal q8.16
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = 22;
    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 16;

    // shared multiplier: 32 x 24 -> 56
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int STEP_W  = 32;
    localparam int STEP2_W = PROD_W - COEF_FRAC;
    localparam int SUM_W   = STEP2_W + 1;

    // divider: quotient bits kept below the overflow flag
    localparam int QUOT_W  = 25;
    localparam int DIV_PRE = QUOT_W - COEF_FRAC;
    localparam int DCNT_W  = $clog2(QUOT_W + 1);

    localparam logic [SUM_W-1:0]  PH_ONE   = SUM_W'(1) << PHASE_FRAC_BITS;
    localparam logic [COEF_W-1:0] CO_ONE   = COEF_W'(1) << COEF_FRAC;
    localparam logic [QUOT_W-1:0] CO_TWO   = QUOT_W'(2) << COEF_FRAC;
    localparam logic [QUOT_W-1:0] CO_HALF  = QUOT_W'(1) << (COEF_FRAC - 1);
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_STEP,
        S_MUL_COEF,
        S_RAMP_MAIN,
        S_MAIN_INC,
        S_MUL_COMP,
        S_RAMP_COMP,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_STEP,
        OP_MUL_COEF,
        OP_RAMP_MAIN,
        OP_MAIN_INC,
        OP_MUL_COMP,
        OP_RAMP_COMP,
        OP_COMMIT_SYNC,
        OP_COMMIT_PLAIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sync_enable;
        logic div_done;
    } dp_status_t;

    // add, drop to zero once strictly past 1.0
    function automatic logic [PHASE_W-1:0] ramp_advance(
        input logic [PHASE_W-1:0] phs,
        input logic [STEP2_W-1:0] inc
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(phs) + SUM_W'(inc);
        if (sum > PH_ONE)
        begin
            return '0;
        end
        return sum[PHASE_W-1:0];
    endfunction

endpackage

// ===== design/phr_divider.sv =====
// ----------------------------------------------------------------------------
// phr_divider: restoring divider for the correction coefficient
// (hi << 22) / divisor, one quotient bit per cycle, overflow flagged up front
// ----------------------------------------------------------------------------
module phr_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [phr_pkg::PHASE_W-1:0]   dividend_hi,
    input  logic [phr_pkg::PHASE_W-1:0]   divisor,
    output logic [phr_pkg::QUOT_W-1:0]    quotient,
    output logic                          ovf,
    output logic                          done
);
    import phr_pkg::*;

    logic                busy_reg, busy_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [PHASE_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0]   sh_reg, sh_next;
    logic                ovf_reg, ovf_next;
    logic [PHASE_W-1:0]  div_reg, div_next;
    logic [PHASE_W:0]    trial;
    logic [PHASE_W-1:0]  hi_pre;

    assign hi_pre = dividend_hi >> DIV_PRE;
    assign trial  = {rem_reg, sh_reg[QUOT_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        ovf_next  = ovf_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(QUOT_W);
            rem_next  = hi_pre;
            sh_next   = QUOT_W'({dividend_hi, {COEF_FRAC{1'b0}}});
            ovf_next  = (hi_pre >= divisor);
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = PHASE_W'(trial - {1'b0, div_reg});
                sh_next  = {sh_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PHASE_W-1:0];
                sh_next  = {sh_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        ovf_reg <= ovf_next;
        div_reg <= div_next;
    end

    assign quotient = sh_reg;
    assign ovf      = ovf_reg;
    assign done     = !busy_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == DCNT_W'(QUOT_W))
        else $error("divider did not start");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == DCNT_W'(1)) |=> !busy_reg)
        else $error("divider overran its count");

endmodule

// ===== design/phr_datapath.sv =====
// ----------------------------------------------------------------------------
// phr_datapath: state, configuration, shared multiplier and divider
// executes one controller command per cycle
// ----------------------------------------------------------------------------
module phr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  phr_pkg::dp_cmd_t               cmd,
    output phr_pkg::dp_status_t            status,
    input  logic [phr_pkg::PHASE_W-1:0]    in_phase,
    input  logic                           cfg_we,
    input  logic [phr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phr_pkg::SCALE_W-1:0]    cfg_data,
    output logic [phr_pkg::PHASE_W-1:0]    out_phase
);
    import phr_pkg::*;

    // configuration
    logic                sync_en_reg, sync_en_next;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic [SCALE_W-1:0]  recip_reg, recip_next;

    // block state
    logic [PHASE_W-1:0]  main_phase_reg, main_phase_next;
    logic [PHASE_W-1:0]  comp_now_reg, comp_now_next;
    logic [PHASE_W-1:0]  comp_old_reg, comp_old_next;
    logic [PHASE_W-1:0]  ext_now_reg, ext_now_next;
    logic [PHASE_W-1:0]  ext_old_reg, ext_old_next;
    logic [COEF_W-1:0]   coef_reg, coef_next;
    logic [PHASE_W-1:0]  ext_inc_reg, ext_inc_next;
    logic [PHASE_W-1:0]  main_inc_reg, main_inc_next;

    // working registers
    logic [PHASE_W-1:0]  ext_in_reg, ext_in_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PHASE_W-1:0]  pr_reg, pr_next;
    logic [PHASE_W-1:0]  pc_reg, pc_next;
    logic [PHASE_W-1:0]  out_reg, out_next;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [STEP_W-1:0]   step;
    logic [STEP2_W-1:0]  step2;

    logic [QUOT_W-1:0]   div_q;
    logic                div_ovf;
    logic                div_done;
    logic [QUOT_W-1:0]   c_cand;
    logic                c_ovf;

    phr_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.op == OP_LOAD),
        .dividend_hi (ext_old_reg),
        .divisor     (comp_old_reg),
        .quotient    (div_q),
        .ovf         (div_ovf),
        .done        (div_done)
    );

    assign step  = prod_reg[SCALE_FRAC +: STEP_W];
    assign step2 = prod_reg[COEF_FRAC +: STEP2_W];

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_COEF:
            begin
                mul_a = step;
                mul_b = coef_reg;
            end
            OP_MUL_COMP:
            begin
                mul_a = MUL_A_W'(recip_reg);
                mul_b = main_inc_reg;
            end
            default:
            begin
                mul_a = MUL_A_W'(scale_reg);
                mul_b = ext_inc_reg;
            end
        endcase
    end

    // coefficient candidate, range checked at commit
    always_comb
    begin
        if (comp_old_reg != '0)
        begin
            c_cand = div_q;
            c_ovf  = div_ovf;
        end
        else
        begin
            c_cand = QUOT_W'(coef_reg);
            c_ovf  = 1'b0;
        end
    end

    always_comb
    begin
        sync_en_next    = sync_en_reg;
        scale_next      = scale_reg;
        recip_next      = recip_reg;
        main_phase_next = main_phase_reg;
        comp_now_next   = comp_now_reg;
        comp_old_next   = comp_old_reg;
        ext_now_next    = ext_now_reg;
        ext_old_next    = ext_old_reg;
        coef_next       = coef_reg;
        ext_inc_next    = ext_inc_reg;
        main_inc_next   = main_inc_reg;
        ext_in_next     = ext_in_reg;
        prod_next       = prod_reg;
        pr_next         = pr_reg;
        pc_next         = pc_reg;
        out_next        = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_ENABLE: sync_en_next = cfg_data[0];
                REG_SCALE:       scale_next   = cfg_data;
                REG_SCALE_RECIP: recip_next   = cfg_data;
                default:         ;
            endcase
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                ext_in_next = in_phase;
                if (in_phase > ext_now_reg)
                begin
                    ext_inc_next = in_phase - ext_now_reg;
                end
            end
            OP_MUL_STEP, OP_MUL_COEF, OP_MUL_COMP:
            begin
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_RAMP_MAIN:
            begin
                pr_next = ramp_advance(main_phase_reg, step2);
            end
            OP_MAIN_INC:
            begin
                if (pr_reg > main_phase_reg)
                begin
                    main_inc_next = pr_reg - main_phase_reg;
                end
            end
            OP_RAMP_COMP:
            begin
                pc_next = ramp_advance(comp_now_reg, STEP2_W'(step));
            end
            OP_COMMIT_SYNC:
            begin
                if (c_ovf || c_cand > CO_TWO || c_cand < CO_HALF)
                begin
                    coef_next = CO_ONE;
                end
                else
                begin
                    coef_next = c_cand[COEF_W-1:0];
                end
                main_phase_next = pr_reg;
                comp_old_next   = comp_now_reg;
                comp_now_next   = pc_reg;
                ext_old_next    = ext_now_reg;
                ext_now_next    = ext_in_reg;
                out_next        = pr_reg;
            end
            OP_COMMIT_PLAIN:
            begin
                main_phase_next = ramp_advance(main_phase_reg, STEP2_W'(step));
                ext_now_next    = ext_in_reg;
                out_next        = main_phase_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_en_reg    <= 1'b1;
            scale_reg      <= SCALE_ONE;
            recip_reg      <= SCALE_ONE;
            main_phase_reg <= '0;
            comp_now_reg   <= '0;
            comp_old_reg   <= '0;
            ext_now_reg    <= '0;
            ext_old_reg    <= '0;
            coef_reg       <= CO_ONE;
            ext_inc_reg    <= '0;
            main_inc_reg   <= '0;
        end
        else
        begin
            sync_en_reg    <= sync_en_next;
            scale_reg      <= scale_next;
            recip_reg      <= recip_next;
            main_phase_reg <= main_phase_next;
            comp_now_reg   <= comp_now_next;
            comp_old_reg   <= comp_old_next;
            ext_now_reg    <= ext_now_next;
            ext_old_reg    <= ext_old_next;
            coef_reg       <= coef_next;
            ext_inc_reg    <= ext_inc_next;
            main_inc_reg   <= main_inc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ext_in_reg <= ext_in_next;
        prod_reg   <= prod_next;
        pr_reg     <= pr_next;
        pc_reg     <= pc_next;
        out_reg    <= out_next;
    end

    assign status.sync_enable = sync_en_reg;
    assign status.div_done    = div_done;
    assign out_phase          = out_reg;

endmodule

// ===== design/phr_ctrl.sv =====
// ----------------------------------------------------------------------------
// phr_ctrl: sequencing state machine of the phase rescaler
// steps the datapath through one item and owns the output valid flag
// ----------------------------------------------------------------------------
module phr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  phr_pkg::dp_status_t  status,
    output phr_pkg::dp_cmd_t     cmd
);
    import phr_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MUL_STEP;
                end
            end
            S_MUL_STEP:
            begin
                cmd.op     = OP_MUL_STEP;
                state_next = status.sync_enable ? S_MUL_COEF : S_FINISH;
            end
            S_MUL_COEF:
            begin
                cmd.op     = OP_MUL_COEF;
                state_next = S_RAMP_MAIN;
            end
            S_RAMP_MAIN:
            begin
                cmd.op     = OP_RAMP_MAIN;
                state_next = S_MAIN_INC;
            end
            S_MAIN_INC:
            begin
                cmd.op     = OP_MAIN_INC;
                state_next = S_MUL_COMP;
            end
            S_MUL_COMP:
            begin
                cmd.op     = OP_MUL_COMP;
                state_next = S_RAMP_COMP;
            end
            S_RAMP_COMP:
            begin
                cmd.op     = OP_RAMP_COMP;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!status.sync_enable && slot_free)
                begin
                    cmd.op         = OP_COMMIT_PLAIN;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (status.sync_enable && status.div_done && slot_free)
                begin
                    cmd.op         = OP_COMMIT_SYNC;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COMMIT_SYNC || cmd.op == OP_COMMIT_PLAIN) |-> slot_free)
        else $error("commit over an untaken result");
    a_commit_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COMMIT_SYNC) |-> status.div_done)
        else $error("sync commit before divider finished");
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COMMIT_SYNC || cmd.op == OP_COMMIT_PLAIN) |=> out_valid_reg)
        else $error("commit without output valid");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_MUL_STEP && !in_ready)
        else $error("accept did not start a run");

endmodule

// ===== design/phase_rescaler.sv =====
// ----------------------------------------------------------------------------
// phase_rescaler: rescaled ramp phase with drift correction
// follows an external ramp phase and produces a ramp at scale times its rate
// ----------------------------------------------------------------------------
//
//  channel  | direction | signals                              | payload
//  ---------+-----------+--------------------------------------+----------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata[23:0]     | ext_phase
//  m_axis   | out       | m_axis_tvalid/tready/tdata[23:0]     | out_phase
//  cfg      | in        | cfg_valid/ready, cfg_index, cfg_data | register write
//
//  timing: a new beat is taken only after the previous item commits; sync
//  mode commits wait for the one-bit-per-cycle coefficient divider (25 steps)
//  that runs beside the shared 32x24 multiplier sequence
//  reset: rst_n clears control and state at once, no clearing pass
//  stalls: the result waits in the output register; a new beat is taken
//  while it waits, and the commit of that item holds until the slot frees
//  cfg: cfg_ready is always high; writes are meant for idle periods only
//
module phase_rescaler (
    input  logic                           clk,
    input  logic                           rst_n,
    // input beat
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,   // [23:0] ext_phase
    // result beat
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,   // [23:0] out_phase
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [phr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phr_pkg::SCALE_W-1:0]    cfg_data
);
    import phr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // writes are always accepted and go straight into the configuration registers
    assign cfg_ready = 1'b1;

    // sequencer: one command per cycle, owns the handshakes
    phr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // state, multiplier, divider and output register
    phr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_phase  (s_axis_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_phase (m_axis_tdata)
    );

endmodule

// ===== test/tb_phase_rescaler.sv =====
// ----------------------------------------------------------------------------
// tb_phase_rescaler: self-checking testbench of the phase rescaler
// drives ext_phase beats, predicts each out_phase beat with a local model of
// the ramp, coefficient and compensating phase, and checks every result beat
// ----------------------------------------------------------------------------
module tb_phase_rescaler;

    import phr_pkg::*;

    // config index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [63:0] PHASE_ONE = 64'd1 << PHASE_FRAC_BITS;
    localparam logic [63:0] COEF_ONE  = 64'd1 << COEF_FRAC;
    localparam logic [63:0] COEF_TWO  = 64'd2 << COEF_FRAC;
    localparam logic [63:0] COEF_HALF = 64'd1 << (COEF_FRAC - 1);

    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 135;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 40;

    // directed row: input phase, and the result where it is typed in by hand
    typedef struct packed {
        logic [23:0] phase;
        logic        typed;
        logic [23:0] result;
    } dir_row_t;

    localparam int DIR_N = 22;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{24'h000000, 1'b1, 24'h000000},   // first beat after reset, no rise
        '{24'h800000, 1'b1, 24'h800000},   // full step lands exactly on 1.0, kept
        '{24'h800000, 1'b1, 24'h000000},   // sum past 1.0 wraps to zero
        '{24'h000000, 1'b1, 24'h800000},   // falling input keeps the held step
        '{24'hFFFFFF, 1'b0, 24'h000000},   // input above 1.0 used as given
        '{24'h7FFFFF, 1'b0, 24'h000000},
        '{24'h000001, 1'b0, 24'h000000},
        '{24'h000000, 1'b0, 24'h000000},
        '{24'h100000, 1'b0, 24'h000000},   // clean ramp, 1/8 per beat
        '{24'h200000, 1'b0, 24'h000000},
        '{24'h300000, 1'b0, 24'h000000},
        '{24'h400000, 1'b0, 24'h000000},
        '{24'h500000, 1'b0, 24'h000000},
        '{24'h600000, 1'b0, 24'h000000},
        '{24'h700000, 1'b0, 24'h000000},
        '{24'h800000, 1'b0, 24'h000000},
        '{24'h800001, 1'b0, 24'h000000},   // just past 1.0
        '{24'h000000, 1'b0, 24'h000000},
        '{24'hAAAAAA, 1'b0, 24'h000000},
        '{24'h555555, 1'b0, 24'h000000},
        '{24'h080000, 1'b0, 24'h000000},
        '{24'h100000, 1'b0, 24'h000000}
    };

    // ------------------------------------------------------------------
    // clock, reset and block ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;      // [23:0] ext_phase
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;            // [23:0] out_phase
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [SCALE_W-1:0]    cfg_data      = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    phase_rescaler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // local copy of the block: registers and ramp state at reset values
    // ------------------------------------------------------------------
    logic        cf_sync  = 1'b1;
    logic [23:0] cf_scale = 24'd65536;
    logic [23:0] cf_recip = 24'd65536;

    logic [23:0] rs_main      = '0;
    logic [23:0] rs_comp_now  = '0;
    logic [23:0] rs_comp_old  = '0;
    logic [23:0] rs_ext_now   = '0;
    logic [23:0] rs_ext_old   = '0;
    logic [23:0] rs_coef      = 24'(COEF_ONE);
    logic [23:0] rs_ext_inc   = '0;
    logic [23:0] rs_main_inc  = '0;

    // add, and drop to zero once strictly past 1.0 (exactly 1.0 is kept)
    function automatic logic [23:0] ramp_wrap(input logic [23:0] phs, input logic [63:0] inc);
        logic [63:0] sum;
        sum = 64'(phs) + inc;
        if (sum > PHASE_ONE)
        begin
            return '0;
        end
        return sum[23:0];
    endfunction

    // next out_phase for one accepted ext_phase, advances the local state
    function automatic logic [23:0] rescale_predict(input logic [23:0] ext);
        logic [63:0] step;
        logic [63:0] cstep;
        logic [63:0] quot;
        logic [23:0] nxt_main;
        logic [23:0] nxt_comp;
        // a rising input reloads the held increment
        if (ext > rs_ext_now)
        begin
            rs_ext_inc = ext - rs_ext_now;
        end
        step = (64'(cf_scale) * 64'(rs_ext_inc)) >> SCALE_FRAC;
        // plain mode: only the main phase, input phase and increment move
        if (!cf_sync)
        begin
            rs_main    = ramp_wrap(rs_main, step);
            rs_ext_now = ext;
            return rs_main;
        end
        step     = (step * 64'(rs_coef)) >> COEF_FRAC;
        nxt_main = ramp_wrap(rs_main, step);
        if (nxt_main > rs_main)
        begin
            rs_main_inc = nxt_main - rs_main;
        end
        cstep    = (64'(cf_recip) * 64'(rs_main_inc)) >> SCALE_FRAC;
        nxt_comp = ramp_wrap(rs_comp_now, cstep);
        // zero divisor keeps the coefficient, the range check still applies
        quot = 64'(rs_coef);
        if (rs_comp_old != '0)
        begin
            quot = (64'(rs_ext_old) << COEF_FRAC) / 64'(rs_comp_old);
        end
        if (quot > COEF_TWO || quot < COEF_HALF)
        begin
            quot = COEF_ONE;
        end
        rs_coef     = quot[23:0];
        rs_main     = nxt_main;
        rs_comp_old = rs_comp_now;
        rs_comp_now = nxt_comp;
        rs_ext_old  = rs_ext_now;
        rs_ext_now  = ext;
        return nxt_main;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared between the driver, receiver and checker
    // ------------------------------------------------------------------
    logic [23:0] out_phase_q [$];     // expected out_phase beats, oldest first
    logic        cur_typed     = 1'b0;
    logic [23:0] cur_typed_val = '0;
    int          send_idle     = 0;   // sender idle percent
    int          rcv_stall     = 0;   // receiver stall percent
    logic        pressure_go   = 1'b0;
    logic        rcv_hold      = 1'b0;

    int mismatches   = 0;
    int n_in_beats   = 0;
    int n_out_beats  = 0;
    int n_sync_beats = 0;
    int n_cfg_writes = 0;
    int n_in_stalls  = 0;

    // receiver: random stalls, or a long hold while the pressure stretch runs
    always @(posedge clk)
    begin
        m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_stall);
    end

    // long receiver hold-off, counted here; sender keeps offering meanwhile
    initial
    begin : hold_off
        do
        begin
            @(posedge clk);
        end
        while (!pressure_go);
        rcv_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rcv_hold <= 1'b0;
    end

    // checker: result beats first, then register writes, then input beats
    always @(posedge clk)
    begin : scoreboard
        logic [23:0] exp_val;
        logic [23:0] pred;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (out_phase_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("result beat %0d with nothing expected: out_phase %h",
                                 n_out_beats, m_axis_tdata);
                    end
                    mismatches++;
                end
                else
                begin
                    exp_val = out_phase_q.pop_front();
                    if (m_axis_tdata !== exp_val)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("result beat %0d out_phase: expected %h got %h",
                                     n_out_beats, exp_val, m_axis_tdata);
                        end
                        mismatches++;
                    end
                end
                n_out_beats++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SYNC_ENABLE: cf_sync  = cfg_data[0];
                    REG_SCALE:       cf_scale = cfg_data;
                    REG_SCALE_RECIP: cf_recip = cfg_data;
                    default: ;
                endcase
                n_cfg_writes++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (cf_sync)
                begin
                    n_sync_beats++;
                end
                pred = rescale_predict(s_axis_tdata);
                out_phase_q.push_back(cur_typed ? cur_typed_val : pred);
                n_in_beats++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                n_in_stalls++;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver tasks, all called at a rising edge
    // ------------------------------------------------------------------

    // offer one ext_phase beat after a random idle gap, return on acceptance
    task automatic send_phase(input logic [23:0] phase, input logic typed,
                              input logic [23:0] result);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= phase;
        cur_typed     <= typed;
        cur_typed_val <= result;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // one register write beat; the caller lowers cfg_valid after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    // wait until every expected result has come back, then let it settle
    task automatic drain();
        while (out_phase_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int          p;
        int          i;
        int          ramp_pos;
        int          ramp_inc;
        logic        w_sync;
        logic [23:0] w_scale;
        logic [23:0] w_recip;
        logic [23:0] ph;
        int          n_items;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings, no idling
        for (i = 0; i < DIR_N; i++)
        begin
            send_phase(DIR_ROWS[i].phase, DIR_ROWS[i].typed, DIR_ROWS[i].result);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        for (p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:  begin w_sync = 1'b1; w_scale = 24'd65536;  w_recip = 24'd65536;  end
                1:  begin w_sync = 1'b1; w_scale = 24'd131072; w_recip = 24'd32768;  end
                2:  begin w_sync = 1'b0; w_scale = 24'hFFFFFF; w_recip = 24'd1;      end
                3:  begin w_sync = 1'b1; w_scale = 24'd1;      w_recip = 24'hFFFFFF; end
                4:  begin w_sync = 1'b1; w_scale = 24'd0;      w_recip = 24'd0;      end
                5:  begin w_sync = 1'b1; w_scale = 24'd65536;  w_recip = 24'd65536;  end
                6:  begin w_sync = 1'b0; w_scale = 24'd32768;  w_recip = 24'd131072; end
                7:  begin w_sync = 1'b1; w_scale = 24'd196608; w_recip = 24'd21845;  end
                8:  begin w_sync = 1'b0; w_scale = 24'd65536;  w_recip = 24'd65536;  end
                9:
                begin
                    // random ratio with a consistent reciprocal
                    w_sync  = 1'b1;
                    w_scale = 24'($urandom_range(16384, 262144));
                    w_recip = 24'((64'd1 << 32) / 64'(w_scale));
                end
                10:
                begin
                    w_sync  = 1'b1;
                    w_scale = 24'($urandom());
                    w_recip = 24'($urandom());
                end
                default: begin w_sync = 1'b1; w_scale = 24'd98304; w_recip = 24'd43690; end
            endcase

            // registers only change with the block idle
            write_reg(REG_SYNC_ENABLE, {23'd0, w_sync});
            write_reg(REG_SCALE, w_scale);
            write_reg(REG_SCALE_RECIP, w_recip);
            if (p == 4)
            begin
                // an index past the last register must leave everything alone
                write_reg(REG_UNUSED, 24'($urandom()));
            end
            cfg_valid <= 1'b0;

            if (p == 5)
            begin
                // pressure stretch: sender always offering, receiver held off
                send_idle   <= 0;
                rcv_stall   <= 0;
                pressure_go <= 1'b1;
            end
            else
            begin
                // idling pattern rotates: none, sender, receiver, both
                case (p % 4)
                    0:       begin send_idle <= 0;  rcv_stall <= 0;  end
                    1:       begin send_idle <= 47; rcv_stall <= 0;  end
                    2:       begin send_idle <= 0;  rcv_stall <= 47; end
                    default: begin send_idle <= 32; rcv_stall <= 32; end
                endcase
            end
            @(posedge clk);

            // zero scale holds the phase, so a short stretch is enough
            n_items  = (p == 4) ? 40 : PHASE_LEN;
            ramp_pos = 0;
            ramp_inc = $urandom_range(1, 24'h20000);
            for (i = 0; i < n_items; i++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    // new ramp rate, mostly slow, sometimes very fast
                    if ($urandom_range(9) == 0)
                    begin
                        ramp_inc = $urandom_range(1, 24'h7FFFFF);
                    end
                    else
                    begin
                        ramp_inc = $urandom_range(1, 24'h20000);
                    end
                end
                if ($urandom_range(99) < 12)
                begin
                    // noise beats: anything the field allows
                    case ($urandom_range(3))
                        0:       ph = 24'($urandom());
                        1:       ph = 24'h000000;
                        2:       ph = 24'hFFFFFF;
                        default: ph = 24'h800000;
                    endcase
                end
                else
                begin
                    // well-formed ramp that wraps back by 1.0
                    ramp_pos = ramp_pos + ramp_inc;
                    if (ramp_pos > int'(PHASE_ONE))
                    begin
                        ramp_pos = ramp_pos - int'(PHASE_ONE);
                    end
                    ph = 24'(ramp_pos);
                end
                send_phase(ph, 1'b0, 24'h000000);
            end
            s_axis_tvalid <= 1'b0;
            pressure_go   <= 1'b0;
            drain();
        end

        $display("covered %0d input beats (%0d in sync mode), %0d result beats, %0d register writes",
                 n_in_beats, n_sync_beats, n_out_beats, n_cfg_writes);
        $display("over %0d settings, with %0d cycles of input back-pressure",
                 N_PHASES + 1, n_in_stalls);
        if (mismatches == 0 && out_phase_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/phr_pkg.sv
design/phr_divider.sv
design/phr_datapath.sv
design/phr_ctrl.sv
design/phase_rescaler.sv
test/tb_phase_rescaler.sv
